/* src/gps_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// gps_pkg
// Shared constants, types and the exp table for the GBM path step block.
// ----------------------------------------------------------------------------
package gps_pkg;

    localparam int EXP_TABLE_BITS = 6;
    localparam int ROM_SIZE       = 1 << EXP_TABLE_BITS;
    localparam int FRAC_W         = 30 - EXP_TABLE_BITS;

    localparam logic [30:0] LOG2E_Q30 = 31'd1549082005;
    localparam logic [29:0] LN2_Q30   = 30'd744261118;
    localparam logic [30:0] ONE_Q30   = 31'h4000_0000;
    localparam logic [63:0] HALF_Q30  = 64'h2000_0000;

    // x/6 as (x * 43691) >> 18, exact for x below 2^17
    localparam int          DIV6_W     = 18;
    localparam int          DIV6_SHIFT = 18;
    localparam logic [15:0] DIV6_RECIP = 16'd43691;

    localparam int          ADDR_W          = 4;
    localparam logic [31:0] START_PRICE_RST = 32'd6553600;
    localparam logic [15:0] PATH_STEPS_RST  = 16'd252;

    typedef enum logic [1:0] {
        REG_START_PRICE = 2'd0,
        REG_DRIFT_STEP  = 2'd1,
        REG_VOL_STEP    = 2'd2,
        REG_PATH_STEPS  = 2'd3
    } t_reg_idx;

    // one bit per datapath step, driven by the sequencer
    typedef struct packed {
        logic load;
        logic mul_vz;
        logic mul_yh;
        logic mul_yl;
        logic mul_u;
        logic mul_u2;
        logic mul_u3;
        logic calc_p;
        logic mul_m;
        logic mul_pr;
        logic emit;
    } t_dp_cmd;

    typedef logic [ROM_SIZE-1:0][31:0] t_exp_rom;

    // 2^(i/ROM_SIZE) in Q.30 by a 12-term series of exp(i*ln2/ROM_SIZE)
    function automatic logic [31:0] exp_rom_entry(input int unsigned i);
        logic [63:0] a;
        logic [63:0] t;
        logic [63:0] s;
        a = (64'(i) * 64'(LN2_Q30) + (64'd1 << (EXP_TABLE_BITS - 1))) >> EXP_TABLE_BITS;
        t = 64'(ONE_Q30);
        s = t;
        t = (((t * a + HALF_Q30) >> 30) + 64'd0) / 64'd1;  s = s + t;
        t = (((t * a + HALF_Q30) >> 30) + 64'd1) / 64'd2;  s = s + t;
        t = (((t * a + HALF_Q30) >> 30) + 64'd1) / 64'd3;  s = s + t;
        t = (((t * a + HALF_Q30) >> 30) + 64'd2) / 64'd4;  s = s + t;
        t = (((t * a + HALF_Q30) >> 30) + 64'd2) / 64'd5;  s = s + t;
        t = (((t * a + HALF_Q30) >> 30) + 64'd3) / 64'd6;  s = s + t;
        t = (((t * a + HALF_Q30) >> 30) + 64'd3) / 64'd7;  s = s + t;
        t = (((t * a + HALF_Q30) >> 30) + 64'd4) / 64'd8;  s = s + t;
        t = (((t * a + HALF_Q30) >> 30) + 64'd4) / 64'd9;  s = s + t;
        t = (((t * a + HALF_Q30) >> 30) + 64'd5) / 64'd10; s = s + t;
        t = (((t * a + HALF_Q30) >> 30) + 64'd5) / 64'd11; s = s + t;
        t = (((t * a + HALF_Q30) >> 30) + 64'd6) / 64'd12; s = s + t;
        return s[31:0];
    endfunction

    function automatic t_exp_rom build_exp_rom();
        t_exp_rom rom;
        for (int i = 0; i < ROM_SIZE; i++) begin
            rom[i] = exp_rom_entry(i);
        end
        return rom;
    endfunction

    localparam t_exp_rom EXP_ROM = build_exp_rom();

endpackage
`default_nettype wire

/* src/gbm_path_step.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// gbm_path_step
// One exact step of a geometric Brownian motion price path per item.
// ----------------------------------------------------------------------------
// Each accepted item (a Q3.12 normal sample, new-path flag in tuser) moves the
// Q16.16 price by exp(drift_step + vol_step * z), evaluated as a power of two
// from a 64-entry table and a cubic. One item is taken at a time: after the
// accept it runs ten steps through a single shared 33x33 multiplier (eight
// products, the polynomial sum and the final round/scale), and the final step
// waits while an earlier result is still untaken. The result sits in an output
// register, so the next item is taken while it waits. A restart, a finished
// path or path_steps of zero reloads start_price before the step; prices above
// the Q16.16 range clamp to all ones with the saturation flag in tuser.
module gbm_path_step (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    // configuration
    input  wire logic                      psel,
    input  wire logic                      penable,
    input  wire logic                      pwrite,
    input  wire logic [gps_pkg::ADDR_W-1:0] paddr,
    input  wire logic [31:0]               pwdata,
    output logic      [31:0]               prdata,
    output logic                           pready,
    // item input
    input  wire logic                      i_s_tvalid,
    output logic                           o_s_tready,
    input  wire logic [15:0]               i_s_tdata,  // [15:0] normal_sample
    input  wire logic [0:0]                i_s_tuser,  // [0] new_path
    // result output
    output logic                           o_m_tvalid,
    input  wire logic                      i_m_tready,
    output logic      [47:0]               o_m_tdata,  // [31:0] price, [47:32] step_index
    output logic                           o_m_tlast,  // last_step
    output logic      [0:0]                o_m_tuser   // [0] saturated
);
    import gps_pkg::*;

    t_dp_cmd     cmd;
    logic [31:0] start_price;
    logic [31:0] drift_step;
    logic [30:0] vol_step;
    logic [15:0] path_steps;
    logic [31:0] price;
    logic [15:0] step_index;
    logic        last_step;
    logic        saturated;

    gps_regs u_regs (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .o_start_price(start_price),
        .o_drift_step (drift_step),
        .o_vol_step   (vol_step),
        .o_path_steps (path_steps)
    );

    gps_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_tvalid(i_s_tvalid),
        .o_s_tready(o_s_tready),
        .i_m_tready(i_m_tready),
        .o_m_tvalid(o_m_tvalid),
        .o_cmd     (cmd)
    );

    gps_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_normal_sample(i_s_tdata),
        .i_new_path     (i_s_tuser[0]),
        .i_start_price  (start_price),
        .i_drift_step   (drift_step),
        .i_vol_step     (vol_step),
        .i_path_steps   (path_steps),
        .o_price        (price),
        .o_step_index   (step_index),
        .o_last_step    (last_step),
        .o_saturated    (saturated)
    );

    assign o_m_tdata = {step_index, price};
    assign o_m_tlast = last_step;
    assign o_m_tuser = saturated;

`ifndef SYNTH
    // one item at a time: input closes straight after an accept
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> !o_s_tready)
        else $error("input ready while an item is in flight");

    // step numbers run from one upward
    a_step_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[47:32] != 16'd0))
        else $error("step index zero on a valid result");

    // a clamped price is always the top of the range
    a_sat_clamped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser[0]) |-> (o_m_tdata[31:0] == 32'hFFFF_FFFF))
        else $error("saturation flag without clamped price");
`endif

endmodule
`default_nettype wire

/* src/gps_regs.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// gps_regs
// APB register file: start price, drift, volatility and path length.
// ----------------------------------------------------------------------------
module gps_regs (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      psel,
    input  wire logic                      penable,
    input  wire logic                      pwrite,
    input  wire logic [gps_pkg::ADDR_W-1:0] paddr,
    input  wire logic [31:0]               pwdata,
    output logic      [31:0]               prdata,
    output logic                           pready,
    output logic      [31:0]               o_start_price,
    output logic      [31:0]               o_drift_step,
    output logic      [30:0]               o_vol_step,
    output logic      [15:0]               o_path_steps
);
    import gps_pkg::*;

    logic [31:0] r_start_price;
    logic [31:0] r_drift_step;
    logic [30:0] r_vol_step;
    logic [15:0] r_path_steps;
    t_reg_idx    reg_idx;
    logic        wr_en;

    assign reg_idx = t_reg_idx'(paddr[3:2]);
    assign wr_en   = psel & penable & pwrite;
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_price <= START_PRICE_RST;
            r_drift_step  <= '0;
            r_vol_step    <= '0;
            r_path_steps  <= PATH_STEPS_RST;
        end else if (wr_en) begin
            case (reg_idx)
                REG_START_PRICE: r_start_price <= pwdata;
                REG_DRIFT_STEP:  r_drift_step  <= pwdata;
                REG_VOL_STEP:    r_vol_step    <= pwdata[30:0];
                REG_PATH_STEPS:  r_path_steps  <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_START_PRICE: prdata = r_start_price;
            REG_DRIFT_STEP:  prdata = r_drift_step;
            REG_VOL_STEP:    prdata = {1'b0, r_vol_step};
            REG_PATH_STEPS:  prdata = {16'd0, r_path_steps};
            default:         prdata = '0;
        endcase
    end

    assign o_start_price = r_start_price;
    assign o_drift_step  = r_drift_step;
    assign o_vol_step    = r_vol_step;
    assign o_path_steps  = r_path_steps;

endmodule
`default_nettype wire

/* src/gps_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// gps_ctrl
// Sequencer: walks one item through the shared multiplier and owns the
// output valid flag.
// ----------------------------------------------------------------------------
module gps_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_s_tvalid,
    output logic                  o_s_tready,
    input  wire logic             i_m_tready,
    output logic                  o_m_tvalid,
    output gps_pkg::t_dp_cmd      o_cmd
);
    import gps_pkg::*;

    typedef enum logic [10:0] {
        S_IDLE = 11'b000_0000_0001,
        S_VZ   = 11'b000_0000_0010,
        S_YH   = 11'b000_0000_0100,
        S_YL   = 11'b000_0000_1000,
        S_U    = 11'b000_0001_0000,
        S_U2   = 11'b000_0010_0000,
        S_U3   = 11'b000_0100_0000,
        S_P    = 11'b000_1000_0000,
        S_M    = 11'b001_0000_0000,
        S_PR   = 11'b010_0000_0000,
        S_FIN  = 11'b100_0000_0000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   accept;
    logic   out_free;

    assign o_s_tready = (r_state == S_IDLE);
    assign accept     = i_s_tvalid & o_s_tready;
    // result slot is free if empty or being drained this cycle
    assign out_free   = ~r_out_valid | i_m_tready;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (accept) n_state = S_VZ;
            S_VZ:   n_state = S_YH;
            S_YH:   n_state = S_YL;
            S_YL:   n_state = S_U;
            S_U:    n_state = S_U2;
            S_U2:   n_state = S_U3;
            S_U3:   n_state = S_P;
            S_P:    n_state = S_M;
            S_M:    n_state = S_PR;
            S_PR:   n_state = S_FIN;
            S_FIN:  if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd        = '0;
        o_cmd.load   = accept;
        o_cmd.mul_vz = (r_state == S_VZ);
        o_cmd.mul_yh = (r_state == S_YH);
        o_cmd.mul_yl = (r_state == S_YL);
        o_cmd.mul_u  = (r_state == S_U);
        o_cmd.mul_u2 = (r_state == S_U2);
        o_cmd.mul_u3 = (r_state == S_U3);
        o_cmd.calc_p = (r_state == S_P);
        o_cmd.mul_m  = (r_state == S_M);
        o_cmd.mul_pr = (r_state == S_PR);
        o_cmd.emit   = (r_state == S_FIN) & out_free;
    end

    assign n_out_valid = o_cmd.emit | (r_out_valid & ~i_m_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_m_tvalid = r_out_valid;

endmodule
`default_nettype wire

/* src/gps_dp.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// gps_dp
// Datapath: one shared 33x33 signed multiplier, the exp table, path state
// and the result register.
// ----------------------------------------------------------------------------
module gps_dp (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire gps_pkg::t_dp_cmd  i_cmd,
    input  wire logic [15:0]       i_normal_sample,
    input  wire logic              i_new_path,
    input  wire logic [31:0]       i_start_price,
    input  wire logic [31:0]       i_drift_step,
    input  wire logic [30:0]       i_vol_step,
    input  wire logic [15:0]       i_path_steps,
    output logic      [31:0]       o_price,
    output logic      [15:0]       o_step_index,
    output logic                   o_last_step,
    output logic                   o_saturated
);
    import gps_pkg::*;

    // path state
    logic [31:0] r_price;
    logic [15:0] r_step;

    // per-item working registers
    logic signed [15:0]         r_z;
    logic signed [35:0]         r_x;
    logic signed [52:0]         r_acc;
    logic        [5:0]          r_n;
    logic [EXP_TABLE_BITS-1:0]  r_idx;
    logic [FRAC_W-1:0]          r_r;
    logic [FRAC_W-1:0]          r_u;
    logic [FRAC_W-1:0]          r_u2;
    logic [FRAC_W-1:0]          r_u3;
    logic [31:0]                r_rom;
    logic [30:0]                r_p;
    logic [31:0]                r_m;
    logic [63:0]                r_prod;

    // result register
    logic [31:0] r_o_price;
    logic [15:0] r_o_step;
    logic        r_o_last;
    logic        r_o_sat;

    logic [15:0]          path_len;
    logic                 restart;
    logic [32:0]          mul_a;
    logic [32:0]          mul_b;
    logic signed [65:0]   mul_p;
    logic signed [47:0]   vz_sum;
    logic signed [35:0]   x_next;
    logic signed [52:0]   y_sum;
    logic signed [37:0]   y_val;
    logic [63:0]          rnd;
    logic [33:0]          rnd_q;
    logic [DIV6_W-1:0]    div_v;
    logic [DIV6_W+15:0]   div_prod;
    logic [15:0]          div_q;
    logic [FRAC_W:0]      half_u2;
    logic [30:0]          p_next;
    logic [5:0]           sh;
    logic [63:0]          shifted;
    logic                 rbit;
    logic [64:0]          res;
    logic                 sat;
    logic [31:0]          price_next;
    logic [15:0]          step_next;

    assign path_len = (i_path_steps == 16'd0) ? 16'd1 : i_path_steps;
    assign restart  = i_new_path | (r_step >= path_len);

    // operand selection for the shared multiplier
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        if (i_cmd.mul_vz) begin
            mul_a = 33'(i_vol_step);
            mul_b = 33'(r_z);
        end else if (i_cmd.mul_yh) begin
            mul_a = 33'($signed(r_x[35:15]));
            mul_b = 33'(LOG2E_Q30);
        end else if (i_cmd.mul_yl) begin
            mul_a = 33'(r_x[14:0]);
            mul_b = 33'(LOG2E_Q30);
        end else if (i_cmd.mul_u) begin
            mul_a = 33'(r_r);
            mul_b = 33'(LN2_Q30);
        end else if (i_cmd.mul_u2) begin
            mul_a = 33'(r_u);
            mul_b = 33'(r_u);
        end else if (i_cmd.mul_u3) begin
            mul_a = 33'(r_u2);
            mul_b = 33'(r_u);
        end else if (i_cmd.mul_m) begin
            mul_a = 33'(r_rom);
            mul_b = 33'(r_p);
        end else if (i_cmd.mul_pr) begin
            mul_a = 33'(r_price);
            mul_b = 33'(r_m);
        end
    end

    assign mul_p = $signed(mul_a) * $signed(mul_b);

    // x = drift + round(vol * z / 2^12)
    assign vz_sum = $signed(mul_p[47:0]) + 48'sd2048;
    assign x_next = 36'($signed(i_drift_step)) + 36'(vz_sum >>> 12);

    // y = floor(x * log2(e)), split in a high and a low product
    assign y_sum = r_acc + $signed({22'd0, mul_p[45:15]});
    assign y_val = 38'(y_sum >>> 15);

    assign rnd   = mul_p[63:0] + HALF_Q30;
    assign rnd_q = rnd[63:30];

    // polynomial 1 + u + u^2/2 + u^3/6 with rounded halves and sixths
    assign div_v    = DIV6_W'(r_u3) + DIV6_W'(3);
    assign div_prod = (DIV6_W + 16)'(div_v) * (DIV6_W + 16)'(DIV6_RECIP);
    assign div_q    = div_prod[DIV6_SHIFT +: 16];
    assign half_u2  = ({1'b0, r_u2} + (FRAC_W + 1)'(1)) >> 1;
    assign p_next   = ONE_Q30 + 31'(r_u) + 31'(half_u2) + 31'(div_q);

    // scale by 2^n with round half up; n stays within -26..25, so the right
    // shift is always between 5 and 56
    assign sh         = 6'd30 - r_n;
    assign shifted    = r_prod >> sh;
    assign rbit       = r_prod[sh - 6'd1];
    assign res        = {1'b0, shifted} + 65'(rbit);
    assign sat        = |res[64:32];
    assign price_next = sat ? 32'hFFFF_FFFF : res[31:0];
    assign step_next  = r_step + 16'd1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_price <= START_PRICE_RST;
            r_step  <= '0;
        end else if (i_cmd.load && restart) begin
            r_price <= i_start_price;
            r_step  <= '0;
        end else if (i_cmd.emit) begin
            r_price <= price_next;
            r_step  <= step_next;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_z <= $signed(i_normal_sample);
        end
        if (i_cmd.mul_vz) begin
            r_x <= x_next;
        end
        if (i_cmd.mul_yh) begin
            r_acc <= mul_p[52:0];
        end
        if (i_cmd.mul_yl) begin
            r_n   <= y_val[35:30];
            r_idx <= y_val[29 -: EXP_TABLE_BITS];
            r_r   <= y_val[FRAC_W-1:0];
        end
        if (i_cmd.mul_u) begin
            r_u   <= rnd_q[FRAC_W-1:0];
            r_rom <= EXP_ROM[r_idx];
        end
        if (i_cmd.mul_u2) begin
            r_u2 <= rnd_q[FRAC_W-1:0];
        end
        if (i_cmd.mul_u3) begin
            r_u3 <= rnd_q[FRAC_W-1:0];
        end
        if (i_cmd.calc_p) begin
            r_p <= p_next;
        end
        if (i_cmd.mul_m) begin
            r_m <= rnd_q[31:0];
        end
        if (i_cmd.mul_pr) begin
            r_prod <= mul_p[63:0];
        end
        if (i_cmd.emit) begin
            r_o_price <= price_next;
            r_o_step  <= step_next;
            r_o_last  <= (step_next == path_len);
            r_o_sat   <= sat;
        end
    end

    assign o_price      = r_o_price;
    assign o_step_index = r_o_step;
    assign o_last_step  = r_o_last;
    assign o_saturated  = r_o_sat;

endmodule
`default_nettype wire

/* sim/testbench.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the GBM path step block.
// ----------------------------------------------------------------------------
// The bench writes the four step registers over APB and streams normal samples
// in, each with a new-path flag. Every accepted item is run through a local
// bit-exact model of the step (power-of-two split, 64-entry table, cubic), and
// each result is compared field by field with the oldest prediction. A short
// directed table covers reset values, path wrap, zero path length, clamping,
// underflow and a start price changed mid-path. Random phases then follow,
// mostly whole paths, with idle bursts on both sides and one long output stall.
// ----------------------------------------------------------------------------
module testbench;

    import gps_pkg::*;

    localparam longint          LOG2E  = 64'sd1549082005;
    localparam longint unsigned LN2    = 64'd744261118;
    localparam longint unsigned ONE    = 64'd1 << 30;
    localparam longint unsigned HALF   = 64'd1 << 29;
    localparam int              TBL_N  = 64;
    localparam int              N_PHASE = 7;

    typedef struct packed {
        logic [31:0] price;
        logic [15:0] step;
        logic        last;
        logic        sat;
    } t_path_pt;

    typedef struct packed {
        logic       is_reg;
        t_reg_idx   reg_sel;
        logic [31:0] value;
        logic [15:0] z;
        logic       np;
        logic       typed;
        t_path_pt   want;
    } t_row;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [ADDR_W-1:0]   paddr = '0;
    logic [31:0]         pwdata = '0;
    logic [31:0]         prdata;
    logic                pready;
    logic                s_valid = 1'b0;
    logic                s_ready;
    logic [15:0]         s_z = '0;
    logic [0:0]          s_np = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    logic [47:0]         m_data;
    logic                m_last;
    logic [0:0]          m_sat;

    // model state and register copies
    logic [31:0]         start_cfg = START_PRICE_RST;
    logic signed [31:0]  drift_cfg = '0;
    logic [30:0]         vol_cfg = '0;
    logic [15:0]         path_len = PATH_STEPS_RST;
    logic [31:0]         cur_price = START_PRICE_RST;
    logic [15:0]         step_cnt = '0;
    logic [31:0]         pow2_tbl [TBL_N];

    t_path_pt            price_q [$];
    t_row                dir_rows [$];

    bit                  idle_on = 1'b1;
    bit                  hold_req = 1'b0;
    int                  hold_left = 0;
    int                  rx_idle = 0;
    int                  n_err = 0;
    int                  n_items = 0;
    int                  n_out = 0;
    int                  n_sat = 0;
    int                  n_ends = 0;
    int                  n_writes = 0;

    gbm_path_step dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .i_s_tvalid (s_valid),
        .o_s_tready (s_ready),
        .i_s_tdata  (s_z),      // [15:0] normal_sample
        .i_s_tuser  (s_np),     // [0] new_path
        .o_m_tvalid (m_valid),
        .i_m_tready (m_ready),
        .o_m_tdata  (m_data),   // [31:0] price, [47:32] step_index
        .o_m_tlast  (m_last),   // last_step
        .o_m_tuser  (m_sat)     // [0] saturated
    );

    always #4 i_clk = ~i_clk;

    initial begin
        #4000000;
        $display("testbench: done, errors");
        $finish;
    end

    // 2^(i/64) in Q.30, 12-term series of exp(i*ln2/64)
    function automatic void fill_pow2_tbl();
        longint unsigned a;
        longint unsigned t;
        longint unsigned acc;
        for (int i = 0; i < TBL_N; i++) begin
            a   = (longint'(i) * LN2 + 64'd32) >> 6;
            t   = ONE;
            acc = ONE;
            for (longint unsigned k = 1; k <= 12; k++) begin
                t   = (t * a + HALF) >> 30;
                t   = (t + k / 2) / k;
                acc = acc + t;
            end
            pow2_tbl[i] = acc[31:0];
        end
    endfunction

    // one step of the price path; updates the model state
    function automatic t_path_pt advance_price(input logic [15:0] z_raw, input logic np);
        longint          zs, x, xh, xl, y, n, sh;
        longint unsigned f, idx, r, u, u2, u3, p, m, prod, res;
        logic [16:0]     plen;
        t_path_pt        pt;
        zs   = longint'($signed(z_raw));
        plen = (path_len == 16'd0) ? 17'd1 : {1'b0, path_len};
        if (np || ({1'b0, step_cnt} >= plen)) begin
            cur_price = start_cfg;
            step_cnt  = '0;
        end
        x  = longint'(drift_cfg) + ((longint'({1'b0, vol_cfg}) * zs + 64'sd2048) >>> 12);
        // x * log2(e) split in two halves to stay inside 64 bits
        xh = x >>> 15;
        xl = x - xh * 64'sd32768;
        y  = (xh * LOG2E + ((xl * LOG2E) >>> 15)) >>> 15;
        n  = y >>> 30;
        f  = unsigned'(y - (n <<< 30));
        idx = f >> 24;
        r   = f & 64'hFF_FFFF;
        u   = (r * LN2 + HALF) >> 30;
        u2  = (u * u + HALF) >> 30;
        u3  = (u2 * u + HALF) >> 30;
        p   = ONE + u + (u2 + 1) / 2 + (u3 + 3) / 6;
        m   = (64'(pow2_tbl[idx]) * p + HALF) >> 30;
        prod = 64'(cur_price) * m;
        sh  = 64'sd30 - n;
        if (prod == 0 || sh > 63) begin
            res = 0;
        end else if (sh > 0) begin
            res = (prod >> sh) + ((prod >> (sh - 1)) & 64'd1);
        end else if (-sh >= 32) begin
            res = 64'h1_0000_0000;
        end else if (prod > (64'hFFFF_FFFF >> (-sh))) begin
            res = 64'h1_0000_0000;
        end else begin
            res = prod << (-sh);
        end
        pt.sat = (res > 64'hFFFF_FFFF);
        if (pt.sat) begin
            res = 64'hFFFF_FFFF;
        end
        cur_price = res[31:0];
        step_cnt  = step_cnt + 16'd1;
        pt.price  = res[31:0];
        pt.step   = step_cnt;
        pt.last   = ({1'b0, step_cnt} == plen);
        return pt;
    endfunction

    function automatic t_row reg_row(input t_reg_idx r, input logic [31:0] v);
        t_row row;
        row         = '0;
        row.is_reg  = 1'b1;
        row.reg_sel = r;
        row.value   = v;
        return row;
    endfunction

    function automatic t_row item_row(input logic [15:0] z, input logic np);
        t_row row;
        row    = '0;
        row.z  = z;
        row.np = np;
        return row;
    endfunction

    function automatic t_row known_row(input logic [15:0] z, input logic np,
                                       input logic [31:0] price, input logic [15:0] step,
                                       input logic last, input logic sat);
        t_row row;
        row       = item_row(z, np);
        row.typed = 1'b1;
        row.want  = '{price: price, step: step, last: last, sat: sat};
        return row;
    endfunction

    task automatic note_fault(input string msg);
        n_err++;
        if (n_err <= 10) begin
            $display("%s", msg);
        end
    endtask

    task automatic push_item(input logic [15:0] z, input logic np,
                             input bit typed, input t_path_pt want);
        int       gap;
        t_path_pt pred;
        @(negedge i_clk);
        if (idle_on && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 10);
            s_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_valid = 1'b1;
        s_z     = z;
        s_np    = np;
        @(posedge i_clk);
        while (!s_ready) @(posedge i_clk);
        pred = advance_price(z, np);
        price_q.push_back(typed ? want : pred);
        n_items++;
    endtask

    // block is idle once every predicted price has come back
    task automatic settle();
        @(negedge i_clk);
        s_valid = 1'b0;
        while (price_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic program_reg(input t_reg_idx r, input logic [31:0] v);
        settle();
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = ADDR_W'({r, 2'b00});
        pwdata  = v;
        @(negedge i_clk);
        penable = 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        case (r)
            REG_START_PRICE: start_cfg = v;
            REG_DRIFT_STEP:  drift_cfg = v;
            REG_VOL_STEP:    vol_cfg   = v[30:0];
            REG_PATH_STEPS:  path_len  = v[15:0];
            default: ;
        endcase
        n_writes++;
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    function automatic logic [15:0] pick_sample();
        logic [31:0] v;
        if ($urandom_range(0, 7) == 0) begin
            v = $urandom();
        end else begin
            v = $urandom_range(0, 16383) - 32'd8192;
        end
        return v[15:0];
    endfunction

    // mostly whole paths (restart flag on the first item only), some ragged runs
    task automatic run_paths(input int n_want);
        int  sent;
        int  cap;
        int  len;
        bit  tidy;
        sent = 0;
        while (sent < n_want) begin
            cap  = (path_len == 16'd0) ? 1 : ((path_len > 16'd40) ? 40 : int'(path_len));
            tidy = ($urandom_range(0, 3) != 0);
            len  = tidy ? cap : $urandom_range(1, 2 * cap);
            for (int k = 0; k < len; k++) begin
                push_item(pick_sample(), tidy ? (k == 0) : 1'($urandom_range(0, 1)), 1'b0, '0);
                sent++;
            end
        end
    endtask

    // output side: random stalls, plus one long hold-off on request
    always @(negedge i_clk) begin
        if (hold_req) begin
            hold_req  = 1'b0;
            hold_left = 300;
        end
        if (hold_left > 0) begin
            m_ready = 1'b0;
            hold_left--;
        end else if (rx_idle > 0) begin
            m_ready = 1'b0;
            rx_idle--;
        end else if (idle_on && $urandom_range(0, 7) == 0) begin
            m_ready = 1'b0;
            rx_idle = $urandom_range(1, 10) - 1;
        end else begin
            m_ready = 1'b1;
        end
    end

    always @(posedge i_clk) begin : check_out
        t_path_pt got;
        t_path_pt want;
        if (i_rst_n && m_valid && m_ready) begin
            got.price = m_data[31:0];
            got.step  = m_data[47:32];
            got.last  = m_last;
            got.sat   = m_sat[0];
            n_out++;
            if (got.last === 1'b1) n_ends++;
            if (got.sat === 1'b1) n_sat++;
            if (price_q.size() == 0) begin
                note_fault($sformatf("result with nothing pending: price %h step %0d",
                                     got.price, got.step));
            end else begin
                want = price_q.pop_front();
                if (got.price !== want.price || got.step !== want.step ||
                    got.last !== want.last || got.sat !== want.sat) begin
                    note_fault($sformatf(
                        "result %0d: price %h/%h step %0d/%0d last %b/%b sat %b/%b (exp/got)",
                        n_out, want.price, got.price, want.step, got.step,
                        want.last, got.last, want.sat, got.sat));
                end
            end
        end
    end

    initial begin : stimulus
        t_row row;
        fill_pow2_tbl();
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // reset values: zero drift and vol keep the price at 100.0
        dir_rows.push_back(known_row(16'h7FFF, 1'b0, 32'd6553600, 16'd1, 1'b0, 1'b0));
        dir_rows.push_back(known_row(16'h8000, 1'b0, 32'd6553600, 16'd2, 1'b0, 1'b0));
        dir_rows.push_back(known_row(16'h0000, 1'b1, 32'd6553600, 16'd1, 1'b0, 1'b0));
        // two-step paths wrap by themselves
        dir_rows.push_back(reg_row(REG_PATH_STEPS, 32'd2));
        dir_rows.push_back(known_row(16'h1234, 1'b0, 32'd6553600, 16'd2, 1'b1, 1'b0));
        dir_rows.push_back(known_row(16'h0000, 1'b0, 32'd6553600, 16'd1, 1'b0, 1'b0));
        dir_rows.push_back(known_row(16'h0000, 1'b0, 32'd6553600, 16'd2, 1'b1, 1'b0));
        // zero path length behaves as one
        dir_rows.push_back(reg_row(REG_PATH_STEPS, 32'd0));
        dir_rows.push_back(known_row(16'h0000, 1'b0, 32'd6553600, 16'd1, 1'b1, 1'b0));
        dir_rows.push_back(known_row(16'hFFFF, 1'b1, 32'd6553600, 16'd1, 1'b1, 1'b0));
        // clamp at full scale
        dir_rows.push_back(reg_row(REG_START_PRICE, 32'hFFFF_FFFF));
        dir_rows.push_back(reg_row(REG_DRIFT_STEP, 32'h7FFF_FFFF));
        dir_rows.push_back(known_row(16'h0000, 1'b1, 32'hFFFF_FFFF, 16'd1, 1'b1, 1'b1));
        dir_rows.push_back(known_row(16'h0000, 1'b0, 32'hFFFF_FFFF, 16'd1, 1'b1, 1'b1));
        // underflow to zero, and zero sticks
        dir_rows.push_back(reg_row(REG_START_PRICE, 32'd1));
        dir_rows.push_back(reg_row(REG_DRIFT_STEP, 32'h8000_0000));
        dir_rows.push_back(reg_row(REG_PATH_STEPS, 32'd3));
        dir_rows.push_back(known_row(16'h0000, 1'b1, 32'd0, 16'd1, 1'b0, 1'b0));
        dir_rows.push_back(known_row(16'h0000, 1'b0, 32'd0, 16'd2, 1'b0, 1'b0));
        dir_rows.push_back(known_row(16'h0000, 1'b0, 32'd0, 16'd3, 1'b1, 1'b0));
        dir_rows.push_back(reg_row(REG_START_PRICE, 32'd0));
        dir_rows.push_back(reg_row(REG_DRIFT_STEP, 32'h7FFF_FFFF));
        dir_rows.push_back(known_row(16'h0000, 1'b0, 32'd0, 16'd1, 1'b0, 1'b0));
        // new start price only bites at the next restart
        dir_rows.push_back(reg_row(REG_START_PRICE, 32'd6553600));
        dir_rows.push_back(reg_row(REG_DRIFT_STEP, 32'd0));
        dir_rows.push_back(reg_row(REG_PATH_STEPS, 32'd10));
        dir_rows.push_back(known_row(16'h0000, 1'b1, 32'd6553600, 16'd1, 1'b0, 1'b0));
        dir_rows.push_back(reg_row(REG_START_PRICE, 32'd13107200));
        dir_rows.push_back(known_row(16'h0000, 1'b0, 32'd6553600, 16'd2, 1'b0, 1'b0));
        dir_rows.push_back(known_row(16'h0000, 1'b1, 32'd13107200, 16'd1, 1'b0, 1'b0));
        // full-scale vol with extreme samples and drifts
        dir_rows.push_back(reg_row(REG_VOL_STEP, 32'h7FFF_FFFF));
        dir_rows.push_back(reg_row(REG_PATH_STEPS, 32'd65535));
        dir_rows.push_back(item_row(16'h7FFF, 1'b1));
        dir_rows.push_back(item_row(16'h8000, 1'b1));
        dir_rows.push_back(item_row(16'h0001, 1'b0));
        dir_rows.push_back(item_row(16'hFFFF, 1'b0));
        dir_rows.push_back(reg_row(REG_DRIFT_STEP, 32'h8000_0000));
        dir_rows.push_back(item_row(16'h8000, 1'b1));
        dir_rows.push_back(reg_row(REG_DRIFT_STEP, 32'h7FFF_FFFF));
        dir_rows.push_back(item_row(16'h7FFF, 1'b1));

        foreach (dir_rows[i]) begin
            row = dir_rows[i];
            if (row.is_reg) begin
                program_reg(row.reg_sel, row.value);
            end else begin
                push_item(row.z, row.np, row.typed, row.want);
            end
        end

        for (int ph = 0; ph < N_PHASE; ph++) begin
            case (ph)
                2: begin
                    program_reg(REG_START_PRICE, $urandom());
                    program_reg(REG_DRIFT_STEP, $urandom());
                    program_reg(REG_VOL_STEP, $urandom() & 32'h7FFF_FFFF);
                    program_reg(REG_PATH_STEPS, $urandom_range(0, 40));
                end
                4: begin
                    program_reg(REG_START_PRICE, $urandom());
                    program_reg(REG_DRIFT_STEP, 32'h7FFF_FFFF);
                    program_reg(REG_VOL_STEP, 32'h7FFF_FFFF);
                    program_reg(REG_PATH_STEPS, 32'd65535);
                end
                5: begin
                    program_reg(REG_START_PRICE, 32'hFFFF_FFFF);
                    program_reg(REG_DRIFT_STEP, 32'h8000_0000);
                    program_reg(REG_VOL_STEP, 32'd0);
                    program_reg(REG_PATH_STEPS, 32'd1);
                end
                default: begin
                    program_reg(REG_START_PRICE, $urandom_range(655360, 13107200));
                    program_reg(REG_DRIFT_STEP, $urandom_range(0, 2097152) - 32'd1048576);
                    program_reg(REG_VOL_STEP, $urandom_range(32'd1 << 23, 32'd1 << 26));
                    program_reg(REG_PATH_STEPS, $urandom_range(1, 16));
                end
            endcase
            // a calm stretch mid-run, and none at all at the end
            idle_on = (ph != 3) && (ph != N_PHASE - 1);
            if (ph == 1) hold_req = 1'b1;
            run_paths(100);
        end

        settle();
        repeat (40) @(posedge i_clk);
        if (price_q.size() != 0) begin
            note_fault($sformatf("%0d results never arrived", price_q.size()));
        end
        $display("stepped %0d items into %0d results: %0d path ends, %0d clamped prices",
                 n_items, n_out, n_ends, n_sat);
        $display("%0d register writes over directed cases and %0d random phases, %0d faults",
                 n_writes, N_PHASE, n_err);
        if (n_err == 0) begin
            $display("testbench: done, clean");
        end else begin
            $display("testbench: done, errors");
        end
        $finish;
    end

endmodule
`default_nettype wire
